### hw/rtl/gkjh_pkg.sv
// Package for the Gaussian kernel joint histogram.
// Holds sizes, command and register codes, the sequencer states, the kernel table and a saturating add.
// No dependencies.
package gkjh_pkg;

  localparam int NBINS_DEF = 16;
  localparam int ACC_W     = 40;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int MUL_AW    = 24;
  localparam int MUL_BW    = 18;
  localparam int MUL_PW    = MUL_AW + MUL_BW;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  localparam logic [2:0] KIND_ADD   = 3'd0;
  localparam logic [2:0] KIND_JOINT = 3'd1;
  localparam logic [2:0] KIND_XMARG = 3'd2;
  localparam logic [2:0] KIND_YMARG = 3'd3;
  localparam logic [2:0] KIND_CLEAR = 3'd4;

  localparam logic [CFG_IDX_W-1:0] CFG_X_ORIGIN = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_ORIGIN = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_X_WIDTH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_Y_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INV_SIG  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_WEIGHT   = 3'd5;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_DLO,
    ST_DHI,
    ST_DSUM,
    ST_DSQ,
    ST_DCAP,
    ST_INTERP,
    ST_KERN,
    ST_WMUL,
    ST_ACC,
    ST_RWR,
    ST_RDWAIT,
    ST_RDSEL,
    ST_RESP
  } state_t;

  typedef struct packed {
    logic joint;
    logic row;
    logic col;
  } store_we_t;

  function automatic logic [15:0] gauss_tab(input logic [4:0] n);
    logic [15:0] v;
    unique case (n)
      5'd0:  v = 16'd26145;
      5'd1:  v = 16'd15858;
      5'd2:  v = 16'd9618;
      5'd3:  v = 16'd5834;
      5'd4:  v = 16'd3538;
      5'd5:  v = 16'd2146;
      5'd6:  v = 16'd1302;
      5'd7:  v = 16'd790;
      5'd8:  v = 16'd479;
      5'd9:  v = 16'd290;
      5'd10: v = 16'd176;
      5'd11: v = 16'd107;
      5'd12: v = 16'd65;
      5'd13: v = 16'd39;
      5'd14: v = 16'd24;
      5'd15: v = 16'd14;
      5'd16: v = 16'd9;
      default: v = 16'd0;
    endcase
    return v;
  endfunction

  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                              input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
  endfunction

endpackage

### hw/rtl/gkjh_in_if.sv
// Input channel of the joint histogram: command word with handshake.
// Depends on nothing.
interface gkjh_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] x_value;
  logic [31:0] y_value;
  logic        sample_valid;
  logic [3:0]  bin_row;
  logic [3:0]  bin_col;

  modport source (output valid, kind, x_value, y_value, sample_valid, bin_row, bin_col,
                  input ready);
  modport sink (input valid, kind, x_value, y_value, sample_valid, bin_row, bin_col,
                output ready);
endinterface

### hw/rtl/gkjh_out_if.sv
// Result channel of the joint histogram: read value with handshake.
// Depends on nothing.
interface gkjh_out_if;
  logic        valid;
  logic        ready;
  logic [39:0] read_value;

  modport source (output valid, read_value, input ready);
  modport sink (input valid, read_value, output ready);
endinterface

### hw/rtl/gaussian_kernel_joint_histogram.sv
// Gaussian kernel joint histogram: top level with sequencer and datapath.
// Add sample: one kernel per bin through the shared multiplier.
// Reads: result word valid after the RDWAIT and RDSEL states; clear: zeroes every joint bin and both marginals.
// Throughput is one word at a time; ready only while idle.
// After reset a clearing pass over all bins runs before the first word is taken.
// Depends on gkjh_pkg, gkjh_in_if, gkjh_out_if, gkjh_mul, gkjh_store.
module gaussian_kernel_joint_histogram #(
  parameter int NBINS = gkjh_pkg::NBINS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  gkjh_in_if.sink                         in_ch,
  gkjh_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [gkjh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gkjh_pkg::CFG_W-1:0]      cfg_data
);

  localparam int BW = $clog2(NBINS);
  localparam int AW = $clog2(NBINS*NBINS);
  localparam int CW = $clog2(NBINS*NBINS + 1);
  localparam int DW = $clog2(2*NBINS) + 34;
  localparam int AC = gkjh_pkg::ACC_W;

  gkjh_pkg::state_t state_r, state_nxt;

  logic signed [31:0] x_origin_r, y_origin_r;
  logic [30:0]        x_width_r, y_width_r;
  logic [23:0]        inv_sigma_r;
  logic [15:0]        weight_r;

  logic signed [DW-1:0] dx_r, dy_r;
  logic [BW-1:0]        j_r, k_r;
  logic [CW-1:0]        cnt_r;
  logic                 axis_y_r;
  logic [41:0]          part_r;
  logic [17:0]          s_r;
  logic                 sfar_r, xfar_r, kfar_r;
  logic [35:0]          sxsq_r;
  logic [36:0]          q_r;
  logic [15:0]          kern_r;
  logic [AC-1:0]        row_acc_r;
  logic [2:0]           rd_kind_r;
  logic                 rd_ok_r;
  logic                 out_valid_r;
  logic [AC-1:0]        out_data_r;
  logic signed [31:0]   y_value_hold_r;

  logic [gkjh_pkg::MUL_AW-1:0] mul_a;
  logic [gkjh_pkg::MUL_BW-1:0] mul_b;
  logic [gkjh_pkg::MUL_PW-1:0] mul_r;

  gkjh_pkg::store_we_t st_we;
  logic [AW-1:0] jaddr;
  logic [BW-1:0] raddr, caddr;
  logic [AC-1:0] jwdata, rwdata, cwdata;
  logic [AC-1:0] jrdata_r, rrdata_r, crdata_r;

  logic signed [DW-1:0] dcur;
  logic [DW-1:0]        adist;
  logic                 afar;
  logic [59:0]          dsum;
  logic [15:0]          t_lo, t_hi;
  logic [32:0]          wround;
  logic [AC-1:0]        wext;
  logic                 accept;
  logic                 clr_side;

  assign accept = in_ch.valid && in_ch.ready;
  assign dcur   = axis_y_r ? dy_r : dx_r;
  assign adist  = dcur[DW-1] ? DW'(-dcur) : DW'(dcur);
  assign afar   = (|adist[DW-1:35]) && (|inv_sigma_r);
  assign dsum   = {mul_r[41:0], 18'd0} + 60'(part_r);
  assign t_lo   = gkjh_pkg::gauss_tab({1'b0, q_r[35:32]});
  assign t_hi   = gkjh_pkg::gauss_tab(5'({1'b0, q_r[35:32]} + 5'd1));
  assign wround = mul_r[32:0] + 33'd32768;
  assign wext   = AC'(wround[31:16]);
  assign clr_side = cnt_r < CW'(NBINS);

  gkjh_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_r)
  );

  gkjh_store #(.NBINS(NBINS)) u_store (
    .clk      (clk),
    .we       (st_we),
    .jaddr    (jaddr),
    .raddr    (raddr),
    .caddr    (caddr),
    .jwdata   (jwdata),
    .rwdata   (rwdata),
    .cwdata   (cwdata),
    .jrdata_r (jrdata_r),
    .rrdata_r (rrdata_r),
    .crdata_r (crdata_r)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gkjh_pkg::ST_CLR: begin
        if (cnt_r == CW'(NBINS*NBINS - 1)) state_nxt = gkjh_pkg::ST_IDLE;
      end
      gkjh_pkg::ST_IDLE: begin
        if (accept) begin
          priority case (in_ch.kind)
            gkjh_pkg::KIND_ADD:   if (in_ch.sample_valid) state_nxt = gkjh_pkg::ST_DLO;
            gkjh_pkg::KIND_JOINT,
            gkjh_pkg::KIND_XMARG,
            gkjh_pkg::KIND_YMARG: state_nxt = gkjh_pkg::ST_RDWAIT;
            gkjh_pkg::KIND_CLEAR: state_nxt = gkjh_pkg::ST_CLR;
            default:              state_nxt = gkjh_pkg::ST_IDLE;
          endcase
        end
      end
      gkjh_pkg::ST_DLO:    state_nxt = gkjh_pkg::ST_DHI;
      gkjh_pkg::ST_DHI:    state_nxt = gkjh_pkg::ST_DSUM;
      gkjh_pkg::ST_DSUM:   state_nxt = gkjh_pkg::ST_DSQ;
      gkjh_pkg::ST_DSQ:    state_nxt = gkjh_pkg::ST_DCAP;
      gkjh_pkg::ST_DCAP:   state_nxt = axis_y_r ? gkjh_pkg::ST_INTERP : gkjh_pkg::ST_DLO;
      gkjh_pkg::ST_INTERP: state_nxt = gkjh_pkg::ST_KERN;
      gkjh_pkg::ST_KERN:   state_nxt = gkjh_pkg::ST_WMUL;
      gkjh_pkg::ST_WMUL:   state_nxt = gkjh_pkg::ST_ACC;
      gkjh_pkg::ST_ACC: begin
        state_nxt = (k_r == BW'(NBINS-1)) ? gkjh_pkg::ST_RWR : gkjh_pkg::ST_DLO;
      end
      gkjh_pkg::ST_RWR: begin
        state_nxt = (j_r == BW'(NBINS-1)) ? gkjh_pkg::ST_IDLE : gkjh_pkg::ST_DLO;
      end
      gkjh_pkg::ST_RDWAIT: state_nxt = gkjh_pkg::ST_RDSEL;
      gkjh_pkg::ST_RDSEL:  state_nxt = gkjh_pkg::ST_RESP;
      gkjh_pkg::ST_RESP:   if (out_ch.ready) state_nxt = gkjh_pkg::ST_IDLE;
      default:             state_nxt = gkjh_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state_r == gkjh_pkg::ST_IDLE);
    mul_a  = '0;
    mul_b  = '0;
    st_we  = '0;
    jaddr  = AW'(j_r * BW'(1)) * AW'(NBINS) + AW'(k_r);
    raddr  = j_r;
    caddr  = (state_r == gkjh_pkg::ST_RDWAIT || state_r == gkjh_pkg::ST_RDSEL ||
              state_r == gkjh_pkg::ST_RESP) ? j_r : k_r;
    jwdata = gkjh_pkg::sat_add(jrdata_r, wext);
    cwdata = gkjh_pkg::sat_add(crdata_r, wext);
    rwdata = gkjh_pkg::sat_add(rrdata_r, row_acc_r);
    unique case (state_r)
      gkjh_pkg::ST_CLR: begin
        jaddr  = AW'(cnt_r);
        raddr  = BW'(cnt_r);
        caddr  = BW'(cnt_r);
        jwdata = '0;
        rwdata = '0;
        cwdata = '0;
        st_we.joint = 1'b1;
        st_we.row   = clr_side;
        st_we.col   = clr_side;
      end
      gkjh_pkg::ST_DLO: begin
        mul_a = inv_sigma_r;
        mul_b = adist[17:0];
      end
      gkjh_pkg::ST_DHI: begin
        mul_a = inv_sigma_r;
        mul_b = {1'b0, adist[34:18]};
      end
      gkjh_pkg::ST_DSQ: begin
        mul_a = 24'(s_r);
        mul_b = s_r;
      end
      gkjh_pkg::ST_INTERP: begin
        mul_a = 24'(t_lo - t_hi);
        mul_b = 18'(q_r[31:16]);
      end
      gkjh_pkg::ST_WMUL: begin
        mul_a = 24'(kern_r);
        mul_b = 18'(weight_r);
      end
      gkjh_pkg::ST_ACC: begin
        st_we.joint = 1'b1;
        st_we.col   = 1'b1;
      end
      gkjh_pkg::ST_RWR: begin
        st_we.row = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gkjh_pkg::ST_CLR;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      x_origin_r  <= '0;
      y_origin_r  <= '0;
      x_width_r   <= 31'd65536;
      y_width_r   <= 31'd65536;
      inv_sigma_r <= 24'd131072;
      weight_r    <= 16'd65535;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          gkjh_pkg::CFG_X_ORIGIN: x_origin_r  <= cfg_data;
          gkjh_pkg::CFG_Y_ORIGIN: y_origin_r  <= cfg_data;
          gkjh_pkg::CFG_X_WIDTH:  x_width_r   <= cfg_data[30:0];
          gkjh_pkg::CFG_Y_WIDTH:  y_width_r   <= cfg_data[30:0];
          gkjh_pkg::CFG_INV_SIG:  inv_sigma_r <= cfg_data[23:0];
          gkjh_pkg::CFG_WEIGHT:   weight_r    <= cfg_data[15:0];
          default: begin
          end
        endcase
      end
      if (state_r == gkjh_pkg::ST_CLR) begin
        cnt_r <= cnt_r + CW'(1);
      end else begin
        cnt_r <= '0;
      end
      if (state_r == gkjh_pkg::ST_RDSEL) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      gkjh_pkg::ST_IDLE: begin
        if (accept) begin
          dx_r      <= DW'(signed'({in_ch.x_value, 1'b0})) - DW'(signed'({x_origin_r, 1'b0}))
                       - DW'({1'b0, x_width_r});
          j_r       <= (in_ch.kind == gkjh_pkg::KIND_ADD) ? '0 : BW'(in_ch.bin_row);
          k_r       <= (in_ch.kind == gkjh_pkg::KIND_ADD) ? '0 : BW'(in_ch.bin_col);
          axis_y_r  <= 1'b0;
          row_acc_r <= '0;
          rd_kind_r <= in_ch.kind;
          rd_ok_r   <= (32'(in_ch.bin_row) < NBINS) &&
                       ((in_ch.kind != gkjh_pkg::KIND_JOINT) || (32'(in_ch.bin_col) < NBINS));
        end
      end
      gkjh_pkg::ST_DHI: begin
        part_r <= mul_r[41:0];
      end
      gkjh_pkg::ST_DSUM: begin
        s_r    <= dsum[34:17];
        sfar_r <= afar || (|dsum[59:35]);
      end
      gkjh_pkg::ST_DCAP: begin
        if (axis_y_r) begin
          q_r    <= 37'(sxsq_r) + 37'(mul_r[35:0]);
          kfar_r <= xfar_r || sfar_r;
        end else begin
          sxsq_r   <= mul_r[35:0];
          xfar_r   <= sfar_r;
          axis_y_r <= 1'b1;
          k_r      <= '0;
          dy_r     <= DW'(signed'({y_value_hold_r, 1'b0})) - DW'(signed'({y_origin_r, 1'b0}))
                      - DW'({1'b0, y_width_r});
        end
      end
      gkjh_pkg::ST_KERN: begin
        kern_r <= (kfar_r || q_r[36]) ? '0 : (t_lo - mul_r[31:16]);
      end
      gkjh_pkg::ST_ACC: begin
        row_acc_r <= gkjh_pkg::sat_add(row_acc_r, wext);
        k_r       <= k_r + BW'(1);
        dy_r      <= dy_r - DW'({1'b0, y_width_r, 1'b0});
      end
      gkjh_pkg::ST_RWR: begin
        row_acc_r <= '0;
        j_r       <= j_r + BW'(1);
        axis_y_r  <= 1'b0;
        dx_r      <= dx_r - DW'({1'b0, x_width_r, 1'b0});
      end
      gkjh_pkg::ST_RDSEL: begin
        priority case (rd_kind_r)
          gkjh_pkg::KIND_JOINT: out_data_r <= rd_ok_r ? jrdata_r : '0;
          gkjh_pkg::KIND_XMARG: out_data_r <= rd_ok_r ? rrdata_r : '0;
          default:              out_data_r <= rd_ok_r ? crdata_r : '0;
        endcase
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      y_value_hold_r <= in_ch.y_value;
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.read_value = out_data_r;

endmodule

### hw/rtl/gkjh_mul.sv
// Shared unsigned multiplier with registered product.
// Depends on gkjh_pkg.
module gkjh_mul (
  input  logic                        clk,
  input  logic [gkjh_pkg::MUL_AW-1:0] a,
  input  logic [gkjh_pkg::MUL_BW-1:0] b,
  output logic [gkjh_pkg::MUL_PW-1:0] p_r
);

  always_ff @(posedge clk) begin
    p_r <= gkjh_pkg::MUL_PW'(a) * gkjh_pkg::MUL_PW'(b);
  end

endmodule

### hw/rtl/gkjh_store.sv
// Joint bin memory and row and column marginal memories, registered reads.
// Depends on gkjh_pkg.
module gkjh_store #(
  parameter int NBINS = gkjh_pkg::NBINS_DEF
) (
  input  logic                           clk,
  input  gkjh_pkg::store_we_t            we,
  input  logic [$clog2(NBINS*NBINS)-1:0] jaddr,
  input  logic [$clog2(NBINS)-1:0]       raddr,
  input  logic [$clog2(NBINS)-1:0]       caddr,
  input  logic [gkjh_pkg::ACC_W-1:0]     jwdata,
  input  logic [gkjh_pkg::ACC_W-1:0]     rwdata,
  input  logic [gkjh_pkg::ACC_W-1:0]     cwdata,
  output logic [gkjh_pkg::ACC_W-1:0]     jrdata_r,
  output logic [gkjh_pkg::ACC_W-1:0]     rrdata_r,
  output logic [gkjh_pkg::ACC_W-1:0]     crdata_r
);

  logic [gkjh_pkg::ACC_W-1:0] joint_mem [NBINS*NBINS];
  logic [gkjh_pkg::ACC_W-1:0] row_mem   [NBINS];
  logic [gkjh_pkg::ACC_W-1:0] col_mem   [NBINS];

  always_ff @(posedge clk) begin
    if (we.joint) begin
      joint_mem[jaddr] <= jwdata;
    end
    jrdata_r <= joint_mem[jaddr];
  end

  always_ff @(posedge clk) begin
    if (we.row) begin
      row_mem[raddr] <= rwdata;
    end
    rrdata_r <= row_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (we.col) begin
      col_mem[caddr] <= cwdata;
    end
    crdata_r <= col_mem[caddr];
  end

endmodule
